// File: design/mrr_pkg.sv
// shared types and constants of the modbus rtu register responder
package mrr_pkg;

    localparam logic [15:0] CRC_POLY  = 16'hA001;
    localparam logic [15:0] CRC_INIT  = 16'hFFFF;
    localparam logic [15:0] HOLD_ADDR = 16'h0001;
    localparam int          CRC_STEPS = 8;

    localparam logic [7:0] ERR_NONE   = 8'h00;
    localparam logic [7:0] ERR_CRC    = 8'h01;
    localparam logic [7:0] ERR_CMD    = 8'h02;
    localparam logic [7:0] ERR_REG    = 8'h03;
    localparam logic [7:0] ERR_COUNT  = 8'h04;
    localparam logic [7:0] ERR_SLAVE  = 8'h07;
    localparam logic [7:0] READ_BYTES = 8'h02;

    localparam logic [1:0] CFG_SLAVE = 2'd0;
    localparam logic [1:0] CFG_READ  = 2'd1;
    localparam logic [1:0] CFG_WRITE = 2'd2;

    localparam logic [1:0] KIND_ERR   = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_WRITE = 2'd2;

    typedef struct packed {
        logic       start;
        logic       init;
        logic [7:0] data;
    } t_crc_ctl;

    typedef struct packed {
        logic        busy;
        logic [15:0] crc;
    } t_crc_sts;

endpackage

// File: design/modbus_rtu_register_responder.sv
// modbus rtu responder top: request capture, checks and response sequencing
// a request byte is stored; once the byte two places back exists, it is folded into the
// bit-serial crc (8 steps of the shared crc unit) while busy holds off the next byte; the
// last byte then adds a check state; each response body byte passes select, load and wait
// states (memory read, crc fold, emission), then one per crc byte; results cannot be stalled
// synchronous active-low reset clears the sequencer, byte count and holding register and
// loads the config defaults
module modbus_rtu_register_responder #(
    parameter int FRAME_BYTES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [7:0]  i_rx_byte,
    input  logic        i_frame_end,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    output logic        o_strobe,
    output logic [7:0]  o_tx_byte,
    output logic        o_tx_last,
    output logic [15:0] o_holding_value
);

    localparam int CW = $clog2(FRAME_BYTES + 1);
    localparam int AW = $clog2(FRAME_BYTES);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_RXWAIT = 3'd1;
    localparam logic [2:0] S_CHECK  = 3'd2;
    localparam logic [2:0] S_TXSEL  = 3'd3;
    localparam logic [2:0] S_TXLOAD = 3'd4;
    localparam logic [2:0] S_TXWAIT = 3'd5;
    localparam logic [2:0] S_TXCRC0 = 3'd6;
    localparam logic [2:0] S_TXCRC1 = 3'd7;

    logic [2:0]    r_state;
    logic [CW-1:0] r_count;
    logic          r_ovf;
    logic          r_end;
    logic [15:0]   r_hold;
    logic [7:0]    r_slave;
    logic [7:0]    r_rd_op;
    logic [7:0]    r_wr_op;
    logic          r_strobe;
    logic          r_last;
    logic [7:0]    r_txb;
    logic [CW-1:0] r_tk;
    logic [CW-1:0] r_rlen;
    logic [7:0]    r_err;
    logic [1:0]    r_kind;

    // captured request fields
    logic [7:0]  r_addr;
    logic [7:0]  r_cmd;
    logic [15:0] r_reg;
    logic [15:0] r_data;
    logic [7:0]  r_b1;
    logic [7:0]  r_b2;

    logic              w_accept;
    logic              w_stored;
    logic              w_fold;
    logic [7:0]        w_mem_q;
    logic [7:0]        w_reg_byte;
    logic [7:0]        w_tx_src;
    logic [CW-1:0]     w_tk_inc;
    logic [CW-1:0]     w_body;
    logic [7:0]        n_err;
    logic [1:0]        n_kind;
    logic [CW-1:0]     n_rlen;
    mrr_pkg::t_crc_ctl w_crc_ctl;
    mrr_pkg::t_crc_sts w_crc_sts;

    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && (r_state == S_IDLE);
    assign w_stored = (r_count < CW'(FRAME_BYTES));
    // the byte two places back is known to be covered by the request crc
    assign w_fold   = w_accept && w_stored && (r_count >= CW'(2));
    assign w_tk_inc = r_tk + CW'(1);
    assign w_body   = r_rlen - CW'(2);

    mrr_frame_buf #(
        .DEPTH (FRAME_BYTES)
    ) u_buf (
        .i_clk   (i_clk),
        .i_we    (w_accept && w_stored),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (i_rx_byte),
        .i_raddr (r_tk[AW-1:0]),
        .o_rdata (w_mem_q)
    );

    mrr_crc_serial u_crc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_crc_ctl),
        .o_sts   (w_crc_sts)
    );

    always_comb begin
        case (r_tk)
            CW'(0):  w_reg_byte = r_addr;
            CW'(1):  w_reg_byte = r_cmd;
            CW'(2):  w_reg_byte = (r_kind == mrr_pkg::KIND_ERR) ? r_err : mrr_pkg::READ_BYTES;
            CW'(3):  w_reg_byte = r_hold[15:8];
            default: w_reg_byte = r_hold[7:0];
        endcase
    end

    assign w_tx_src = (r_kind == mrr_pkg::KIND_WRITE) ? w_mem_q : w_reg_byte;

    always_comb begin
        w_crc_ctl.start = w_fold || (r_state == S_TXLOAD);
        if (r_state == S_TXLOAD) begin
            w_crc_ctl.init = (r_tk == '0);
            w_crc_ctl.data = w_tx_src;
        end else begin
            w_crc_ctl.init = (r_count == CW'(2));
            w_crc_ctl.data = r_b2;
        end
    end

    // later checks override earlier codes
    always_comb begin
        n_err = mrr_pkg::ERR_NONE;
        if (r_addr != r_slave) begin
            n_err = mrr_pkg::ERR_SLAVE;
        end
        if ({r_b1, r_b2} != w_crc_sts.crc) begin
            n_err = mrr_pkg::ERR_CRC;
        end
        if ((r_cmd == r_rd_op) && (r_data != 16'h0001)) begin
            n_err = mrr_pkg::ERR_COUNT;
        end
        if (r_reg == mrr_pkg::HOLD_ADDR) begin
            if ((r_cmd != r_rd_op) && (r_cmd != r_wr_op)) begin
                n_err = mrr_pkg::ERR_CMD;
            end
        end else begin
            n_err = mrr_pkg::ERR_REG;
        end
        if (n_err != mrr_pkg::ERR_NONE) begin
            n_kind = mrr_pkg::KIND_ERR;
            n_rlen = CW'(5);
        end else if (r_cmd == r_rd_op) begin
            n_kind = mrr_pkg::KIND_READ;
            n_rlen = CW'(7);
        end else begin
            n_kind = mrr_pkg::KIND_WRITE;
            n_rlen = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovf    <= 1'b0;
            r_end    <= 1'b0;
            r_hold   <= '0;
            r_slave  <= 8'h01;
            r_rd_op  <= 8'h03;
            r_wr_op  <= 8'h06;
            r_strobe <= 1'b0;
            r_last   <= 1'b0;
            r_txb    <= '0;
            r_tk     <= '0;
            r_rlen   <= '0;
            r_err    <= '0;
            r_kind   <= mrr_pkg::KIND_ERR;
        end else begin
            r_strobe <= 1'b0;
            r_last   <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    mrr_pkg::CFG_SLAVE: r_slave <= i_cfg_data;
                    mrr_pkg::CFG_READ:  r_rd_op <= i_cfg_data;
                    mrr_pkg::CFG_WRITE: r_wr_op <= i_cfg_data;
                    default: ;
                endcase
            end
            case (r_state)
                S_IDLE: begin
                    if (start) begin
                        if (w_stored) begin
                            r_count <= r_count + CW'(1);
                        end else begin
                            r_ovf <= 1'b1;
                        end
                        if (w_fold) begin
                            r_end   <= i_frame_end;
                            r_state <= S_RXWAIT;
                        end else if (i_frame_end) begin
                            r_state <= S_CHECK;
                        end
                    end
                end
                S_RXWAIT: begin
                    if (!w_crc_sts.busy) begin
                        r_state <= r_end ? S_CHECK : S_IDLE;
                    end
                end
                S_CHECK: begin
                    r_count <= '0;
                    r_ovf   <= 1'b0;
                    if (r_ovf || (r_count < CW'(4))) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_err  <= n_err;
                        r_kind <= n_kind;
                        r_rlen <= n_rlen;
                        r_tk   <= '0;
                        if (n_kind == mrr_pkg::KIND_WRITE) begin
                            r_hold <= r_data;
                        end
                        r_state <= S_TXSEL;
                    end
                end
                S_TXSEL: begin
                    r_state <= S_TXLOAD;
                end
                S_TXLOAD: begin
                    r_strobe <= 1'b1;
                    r_txb    <= w_tx_src;
                    r_state  <= S_TXWAIT;
                end
                S_TXWAIT: begin
                    if (!w_crc_sts.busy) begin
                        r_tk    <= w_tk_inc;
                        r_state <= (w_tk_inc == w_body) ? S_TXCRC0 : S_TXSEL;
                    end
                end
                S_TXCRC0: begin
                    r_strobe <= 1'b1;
                    r_txb    <= w_crc_sts.crc[7:0];
                    r_state  <= S_TXCRC1;
                end
                S_TXCRC1: begin
                    r_strobe <= 1'b1;
                    r_last   <= 1'b1;
                    r_txb    <= w_crc_sts.crc[15:8];
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // field capture, missing data bytes read as zero
    always_ff @(posedge i_clk) begin
        if (w_accept && w_stored) begin
            r_b2 <= r_b1;
            r_b1 <= i_rx_byte;
            case (r_count)
                CW'(0): begin
                    r_addr <= i_rx_byte;
                    r_data <= '0;
                end
                CW'(1):  r_cmd        <= i_rx_byte;
                CW'(2):  r_reg[15:8]  <= i_rx_byte;
                CW'(3):  r_reg[7:0]   <= i_rx_byte;
                CW'(4):  r_data[15:8] <= i_rx_byte;
                CW'(5):  r_data[7:0]  <= i_rx_byte;
                default: ;
            endcase
        end
    end

    assign o_strobe        = r_strobe;
    assign o_tx_byte       = r_txb;
    assign o_tx_last       = r_last;
    assign o_holding_value = r_hold;

`ifndef SYNTHESIS
    a_crc_busy_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_crc_sts.busy |-> busy)
        else $error("crc unit running while responder idle");

    a_last_has_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_tx_last |-> o_strobe)
        else $error("last flag without strobe");

    a_last_ends_response: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_tx_last) |=> !o_strobe)
        else $error("strobe right after last response byte");

    a_check_crc_settled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK) |-> !w_crc_sts.busy)
        else $error("request checked before crc finished");
`endif

endmodule

// File: design/mrr_crc_serial.sv
// bit-serial crc-16 unit, one data bit per cycle
module mrr_crc_serial (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mrr_pkg::t_crc_ctl i_ctl,
    output mrr_pkg::t_crc_sts o_sts
);

    localparam int CNT_W = $clog2(mrr_pkg::CRC_STEPS + 1);

    logic [15:0]      r_crc;
    logic [7:0]       r_sh;
    logic [CNT_W-1:0] r_cnt;
    logic             w_fb;
    logic [15:0]      n_crc;

    assign w_fb  = r_crc[0] ^ r_sh[0];
    assign n_crc = {1'b0, r_crc[15:1]} ^ (w_fb ? mrr_pkg::CRC_POLY : 16'h0000);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_crc <= mrr_pkg::CRC_INIT;
        end else if (i_ctl.start) begin
            r_cnt <= CNT_W'(mrr_pkg::CRC_STEPS);
            r_crc <= i_ctl.init ? mrr_pkg::CRC_INIT : r_crc;
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CNT_W'(1);
            r_crc <= n_crc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_sh <= i_ctl.data;
        end else if (r_cnt != '0) begin
            r_sh <= {1'b0, r_sh[7:1]};
        end
    end

    assign o_sts.busy = (r_cnt != '0);
    assign o_sts.crc  = r_crc;

endmodule

// File: design/mrr_frame_buf.sv
// request byte store with one write and one registered read port
module mrr_frame_buf #(
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [7:0]               i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [7:0]               o_rdata
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_q;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q <= r_mem[i_raddr];
    end

    assign o_rdata = r_q;

endmodule

// File: bench/tb.sv
// self-checking bench for the modbus rtu register responder: request bytes in, response bytes out
module tb;

    localparam int FRAME_BYTES   = 16;
    localparam int SETTLE_CYCLES = 200;
    localparam int QUIET_LIMIT   = 3000;

    typedef logic [7:0] t_bytes [0:31];

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_req;

    typedef struct packed {
        logic [7:0]  tx;
        logic        last;
        logic [15:0] hold;
    } t_resp;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [7:0]  i_rx_byte;
    logic        i_frame_end;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [7:0]  i_cfg_data;
    logic        o_strobe;
    logic [7:0]  o_tx_byte;
    logic        o_tx_last;
    logic [15:0] o_holding_value;

    modbus_rtu_register_responder #(.FRAME_BYTES(FRAME_BYTES)) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_rx_byte      (i_rx_byte),
        .i_frame_end    (i_frame_end),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_strobe       (o_strobe),
        .o_tx_byte      (o_tx_byte),
        .o_tx_last      (o_tx_last),
        .o_holding_value(o_holding_value)
    );

    t_req  req_pending[$];
    t_resp resp_due[$];

    // responder state as the bench predicts it
    t_bytes      m_store;
    int          m_cnt;
    logic        m_ovf;
    logic [15:0] m_hold;
    logic [7:0]  m_slave;
    logic [7:0]  m_rd;
    logic [7:0]  m_wr;

    // configuration the request generator builds against
    logic [7:0] gen_slave;
    logic [7:0] gen_rd;
    logic [7:0] gen_wr;

    logic taken;
    bit   calm;
    bit   failed;
    int   idle_left = 0;
    int   quiet;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [15:0] crc16(input t_bytes b, input int n);
        logic [15:0] c;
        c = mrr_pkg::CRC_INIT;
        for (int i = 0; i < n; i++) begin
            c = c ^ {8'h00, b[i]};
            for (int s = 0; s < mrr_pkg::CRC_STEPS; s++) begin
                c = c[0] ? ((c >> 1) ^ mrr_pkg::CRC_POLY) : (c >> 1);
            end
        end
        return c;
    endfunction

    // absorb one accepted request byte and queue the response bytes it causes
    task automatic predict_response(input logic [7:0] rx, input logic fe);
        t_bytes      rsp;
        t_resp       e;
        int          len;
        int          rlen;
        logic [7:0]  cmd;
        logic [7:0]  err;
        logic [15:0] reg_addr;
        logic [15:0] data;
        logic [15:0] crc_rx;
        logic [15:0] crc;
        if (m_cnt < FRAME_BYTES) begin
            m_store[m_cnt] = rx;
            m_cnt++;
        end else begin
            m_ovf = 1'b1;
        end
        if (fe) begin
            len = m_cnt;
            m_cnt = 0;
            if (m_ovf || len < 4) begin
                m_ovf = 1'b0;
            end else begin
                cmd = m_store[1];
                reg_addr = {m_store[2], m_store[3]};
                // data bytes that never arrived read as zero
                data = {(len > 4) ? m_store[4] : 8'h00, (len > 5) ? m_store[5] : 8'h00};
                crc_rx = {m_store[len - 1], m_store[len - 2]};
                err = mrr_pkg::ERR_NONE;
                if (m_store[0] != m_slave) err = mrr_pkg::ERR_SLAVE;
                if (crc_rx != crc16(m_store, len - 2)) err = mrr_pkg::ERR_CRC;
                if (cmd == m_rd && data != 16'h0001) err = mrr_pkg::ERR_COUNT;
                if (reg_addr != mrr_pkg::HOLD_ADDR) begin
                    err = mrr_pkg::ERR_REG;
                end else if (cmd != m_rd && cmd != m_wr) begin
                    err = mrr_pkg::ERR_CMD;
                end
                rsp = m_store;
                if (err != mrr_pkg::ERR_NONE) begin
                    rsp[2] = err;
                    rlen = 5;
                end else if (cmd == m_rd) begin
                    rsp[2] = mrr_pkg::READ_BYTES;
                    rsp[3] = m_hold[15:8];
                    rsp[4] = m_hold[7:0];
                    rlen = 7;
                end else begin
                    m_hold = data;
                    rlen = len;
                end
                crc = crc16(rsp, rlen - 2);
                rsp[rlen - 2] = crc[7:0];
                rsp[rlen - 1] = crc[15:8];
                for (int k = 0; k < rlen; k++) begin
                    e.tx = rsp[k];
                    e.last = (k == rlen - 1);
                    e.hold = m_hold;
                    resp_due.push_back(e);
                end
            end
        end
    endtask

    // crc lands on the last two bytes of any request of two bytes or more
    task automatic queue_request(input int len, input logic [7:0] addr, input logic [7:0] cmd,
                                 input logic [15:0] reg_addr, input logic [15:0] data,
                                 input bit bad_crc);
        t_bytes      b;
        logic [15:0] crc;
        for (int k = 0; k < 32; k++) b[k] = 8'($urandom);
        b[0] = addr;
        b[1] = cmd;
        b[2] = reg_addr[15:8];
        b[3] = reg_addr[7:0];
        b[4] = data[15:8];
        b[5] = data[7:0];
        if (len >= 2) begin
            crc = crc16(b, len - 2);
            if (bad_crc) crc = crc ^ (16'h0001 << $urandom_range(15, 0));
            b[len - 2] = crc[7:0];
            b[len - 1] = crc[15:8];
        end
        for (int k = 0; k < len; k++) req_pending.push_back({b[k], k == len - 1});
    endtask

    task automatic queue_random_request();
        int          pick;
        int          len;
        logic [7:0]  addr;
        logic [7:0]  cmd;
        logic [15:0] reg_addr;
        logic [15:0] data;
        bit          bad_crc;
        pick = $urandom_range(99, 0);
        len = ($urandom_range(9, 0) < 7) ? 8 : $urandom_range(16, 4);
        addr = gen_slave;
        reg_addr = mrr_pkg::HOLD_ADDR;
        bad_crc = 1'b0;
        if ($urandom_range(1, 0)) begin
            cmd = gen_rd;
            data = 16'h0001;
        end else begin
            cmd = gen_wr;
            case ($urandom_range(3, 0))
                0: data = 16'h0000;
                1: data = 16'hFFFF;
                default: data = 16'($urandom);
            endcase
        end
        if (pick >= 55 && pick < 80) begin
            // damaged request, several checks may fail at once
            if ($urandom_range(2, 0) == 0) addr = addr ^ 8'($urandom_range(255, 1));
            if ($urandom_range(2, 0) == 0) data = 16'($urandom_range(65535, 2));
            if ($urandom_range(2, 0) == 0) data = 16'h0000;
            if ($urandom_range(2, 0) == 0) cmd = 8'($urandom);
            if ($urandom_range(2, 0) == 0) reg_addr = 16'($urandom);
            bad_crc = ($urandom_range(2, 0) == 0);
        end else if (pick >= 80 && pick < 86) begin
            len = $urandom_range(3, 1);
        end else if (pick >= 86 && pick < 92) begin
            len = $urandom_range(FRAME_BYTES + 4, FRAME_BYTES + 1);
        end else if (pick >= 92) begin
            len = $urandom_range(12, 1);
            addr = 8'($urandom);
            cmd = 8'($urandom);
            reg_addr = 16'($urandom);
            data = 16'($urandom);
            bad_crc = $urandom_range(1, 0);
        end
        queue_request(len, addr, cmd, reg_addr, data, bad_crc);
    endtask

    task automatic queue_random_burst(input int n_bytes);
        int goal;
        goal = req_pending.size() + n_bytes;
        while (req_pending.size() < goal) queue_random_request();
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [7:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
    endtask

    task automatic set_config(input logic [7:0] slave, input logic [7:0] rd,
                              input logic [7:0] wr);
        write_reg(mrr_pkg::CFG_SLAVE, slave);
        write_reg(mrr_pkg::CFG_READ, rd);
        write_reg(mrr_pkg::CFG_WRITE, wr);
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        gen_slave = slave;
        gen_rd = rd;
        gen_wr = wr;
    endtask

    // wait until every request byte is taken and every response byte seen, then let the responder settle
    task automatic drain();
        do @(negedge i_clk);
        while (req_pending.size() != 0 || start || resp_due.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin : drive
        t_req nxt;
        if (i_rst_n && (!start || taken)) begin
            if (idle_left > 0) begin
                idle_left <= idle_left - 1;
                start <= 1'b0;
            end else if (start && !calm && $urandom_range(99, 0) < 12) begin
                idle_left <= $urandom_range(10, 0);
                start <= 1'b0;
            end else if (req_pending.size() != 0) begin
                nxt = req_pending.pop_front();
                start <= 1'b1;
                i_rx_byte <= nxt.data;
                i_frame_end <= nxt.last;
            end else begin
                start <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin : watch
        t_resp want;
        if (!i_rst_n) begin
            taken <= 1'b0;
            quiet <= 0;
            m_cnt = 0;
            m_ovf = 1'b0;
            m_hold = 16'h0000;
            m_slave = 8'h01;
            m_rd = 8'h03;
            m_wr = 8'h06;
        end else begin
            taken <= start && !busy;
            if (o_strobe) begin
                if (resp_due.size() == 0) begin
                    $error("response byte %h with no request pending", o_tx_byte);
                    failed = 1'b1;
                end else begin
                    want = resp_due.pop_front();
                    if (o_tx_byte !== want.tx) begin
                        $error("tx_byte: expected %h, got %h", want.tx, o_tx_byte);
                        failed = 1'b1;
                    end
                    if (o_tx_last !== want.last) begin
                        $error("tx_last: expected %b, got %b", want.last, o_tx_last);
                        failed = 1'b1;
                    end
                    if (o_holding_value !== want.hold) begin
                        $error("holding_value: expected %h, got %h", want.hold,
                               o_holding_value);
                        failed = 1'b1;
                    end
                end
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    mrr_pkg::CFG_SLAVE: m_slave = i_cfg_data;
                    mrr_pkg::CFG_READ:  m_rd = i_cfg_data;
                    mrr_pkg::CFG_WRITE: m_wr = i_cfg_data;
                    default: ;
                endcase
            end
            if (start && !busy) predict_response(i_rx_byte, i_frame_end);
            if (o_strobe || (start && !busy)) begin
                quiet <= 0;
            end else if (quiet >= QUIET_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end else begin
                quiet <= quiet + 1;
            end
        end
    end

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_rx_byte = 8'h00;
        i_frame_end = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = mrr_pkg::CFG_SLAVE;
        i_cfg_data = 8'h00;
        calm = 1'b0;
        failed = 1'b0;
        gen_slave = 8'h01;
        gen_rd = 8'h03;
        gen_wr = 8'h06;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: full-scale write then read back, short request, missing data bytes
        queue_request(8, gen_slave, gen_wr, mrr_pkg::HOLD_ADDR, 16'hFFFF, 1'b0);
        queue_request(8, gen_slave, gen_rd, mrr_pkg::HOLD_ADDR, 16'h0001, 1'b0);
        req_pending.push_back({8'hFF, 1'b0});
        req_pending.push_back({8'h00, 1'b1});
        queue_request(4, gen_slave, gen_wr, mrr_pkg::HOLD_ADDR, 16'h0000, 1'b0);
        queue_request(5, gen_slave, gen_rd, mrr_pkg::HOLD_ADDR, 16'h0001, 1'b0);
        drain();

        set_config(8'h00, 8'hFF, 8'h00);
        queue_random_burst(90);
        drain();

        set_config(8'hFF, 8'h00, 8'hFF);
        queue_random_burst(90);
        drain();

        // same opcode for read and write
        gen_rd = 8'($urandom);
        set_config(8'($urandom), gen_rd, gen_rd);
        queue_random_burst(90);
        drain();

        set_config(8'($urandom), 8'($urandom), 8'($urandom));
        queue_random_burst(90);
        drain();

        calm = 1'b1;
        set_config(8'h01, 8'h03, 8'h06);
        queue_random_burst(80);
        drain();

        if (!failed) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
